// ===== design/gcd_pkg.sv =====
// ----------------------------------------------------------------------------
// gcd_pkg - shared types and constants of the great-circle distance unit
// Fixed-point constants, the arctangent table and the lane record types.
// ----------------------------------------------------------------------------
package gcd_pkg;

    // angle lanes: dlat, dlon, 2*lat_a, 2*lat_b
    localparam int NLANE = 4;
    // square root lanes: sqrt(h), sqrt(1-h)
    localparam int NROOT = 2;

    localparam int CW = 34;          // CORDIC datapath width (Q30, signed)
    localparam int RW = 64;          // root datapath width
    localparam int AW = 51;          // width of mag * (PI_Q30 div 45)
    localparam int TW = 29;          // width of mag * (PI_Q30 mod 45) + half divisor
    localparam int MAX_STEPS = 32;
    localparam int ROOT_STEPS = 32;

    localparam logic signed [26:0] DEG_90  = 27'sd11796480;
    localparam logic signed [26:0] DEG_180 = 27'sd23592960;
    localparam logic signed [26:0] DEG_360 = 27'sd47185920;

    localparam logic [31:0] PI_Q30   = 32'd3373259426;
    localparam logic [31:0] HALF_DEG = 32'd11796480;     // half of 180 * 2^17
    // 180 * 2^17 = 45 * 2^19; PI_Q30 = 45 * PI_DIV45 + PI_MOD45
    localparam logic [26:0] PI_DIV45 = 27'd74961320;
    localparam logic [4:0]  PI_MOD45 = 5'd26;
    // ceil(2^35 / 45), exact quotient for every dividend below 2^29
    localparam logic [29:0] RECIP45  = 30'd763549742;
    localparam int          RECIP_SH = 35;
    localparam logic signed [CW-1:0] GAIN_Q30 = 34'sd652032874;
    localparam logic [30:0] ONE_Q30  = 31'd1073741824;

    localparam logic [13:0] DIST_SCALE = 14'd12742;       // 2 * 6371
    localparam logic [22:0] DIST_MAX   = 23'd5124000;

    // atan(2^-i) in Q30, rounded half up
    localparam logic [31:0] ARC [MAX_STEPS] = '{
        32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159,
        32'd67021687,  32'd33543516,  32'd16775851,  32'd8388437,
        32'd4194283,   32'd2097149,   32'd1048576,   32'd524288,
        32'd262144,    32'd131072,    32'd65536,     32'd32768,
        32'd16384,     32'd8192,      32'd4096,      32'd2048,
        32'd1024,      32'd512,       32'd256,       32'd128,
        32'd64,        32'd32,        32'd16,        32'd8,
        32'd4,         32'd2,         32'd1,         32'd1
    };

    typedef struct packed {
        logic          sign;
        logic          negc;
        logic [AW-1:0] hi;
        logic [TW-1:0] lo;
    } angle_t;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
    } cord_t;

    typedef struct packed {
        logic [RW-1:0] n;
        logic [RW-1:0] res;
    } root_t;

endpackage

// ===== design/gcd_div_cell.sv =====
// ----------------------------------------------------------------------------
// gcd_div_cell - degree-to-radian division by 45
// Divides the low part by a reciprocal multiply and adds the exact high part.
// ----------------------------------------------------------------------------
module gcd_div_cell (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    en,
    input  logic                                    vld_i,
    input  gcd_pkg::angle_t [gcd_pkg::NLANE-1:0]    d_i,
    output logic                                    vld_o,
    output gcd_pkg::angle_t [gcd_pkg::NLANE-1:0]    d_o
);

    localparam int PW = gcd_pkg::TW + 30;

    logic                                 vld_reg;
    gcd_pkg::angle_t [gcd_pkg::NLANE-1:0] d_reg;
    gcd_pkg::angle_t [gcd_pkg::NLANE-1:0] d_next;
    logic [PW-1:0]                        prod [gcd_pkg::NLANE];

    always_comb begin
        for (int k = 0; k < gcd_pkg::NLANE; k++) begin
            prod[k] = PW'(d_i[k].lo) * PW'(gcd_pkg::RECIP45);
            d_next[k].sign = d_i[k].sign;
            d_next[k].negc = d_i[k].negc;
            d_next[k].hi   = d_i[k].hi + gcd_pkg::AW'(prod[k][PW-1:gcd_pkg::RECIP_SH]);
            d_next[k].lo   = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg <= vld_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_reg <= d_next;
        end
    end

    assign vld_o = vld_reg;
    assign d_o   = d_reg;

endmodule

// ===== design/gcd_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// gcd_cordic_cell - one CORDIC micro-rotation at a fixed step index
// Rotation mode steers by the sign of z, vectoring mode by the sign of y.
// ----------------------------------------------------------------------------
module gcd_cordic_cell #(
    parameter int IDX    = 0,
    parameter bit VECTOR = 1'b0,
    parameter int LANES  = 1
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          vld_i,
    input  gcd_pkg::cord_t [LANES-1:0]    d_i,
    output logic                          vld_o,
    output gcd_pkg::cord_t [LANES-1:0]    d_o
);

    localparam logic signed [gcd_pkg::CW-1:0] ARC_STEP =
        signed'(gcd_pkg::CW'(gcd_pkg::ARC[IDX]));

    logic                         vld_reg;
    gcd_pkg::cord_t [LANES-1:0]   d_reg;
    gcd_pkg::cord_t [LANES-1:0]   d_next;
    logic signed [gcd_pkg::CW-1:0] dx [LANES];
    logic signed [gcd_pkg::CW-1:0] dy [LANES];
    logic                         pos [LANES];

    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            dx[k]  = d_i[k].y >>> IDX;
            dy[k]  = d_i[k].x >>> IDX;
            pos[k] = VECTOR ? (d_i[k].y < 0) : (d_i[k].z >= 0);
            if (pos[k]) begin
                d_next[k].x = d_i[k].x - dx[k];
                d_next[k].y = d_i[k].y + dy[k];
                d_next[k].z = d_i[k].z - ARC_STEP;
            end else begin
                d_next[k].x = d_i[k].x + dx[k];
                d_next[k].y = d_i[k].y - dy[k];
                d_next[k].z = d_i[k].z + ARC_STEP;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg <= vld_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_reg <= d_next;
        end
    end

    assign vld_o = vld_reg;
    assign d_o   = d_reg;

endmodule

// ===== design/gcd_root_cell.sv =====
// ----------------------------------------------------------------------------
// gcd_root_cell - one digit of the bit-by-bit integer square root
// Tries the current root bit against the remaining radicand.
// ----------------------------------------------------------------------------
module gcd_root_cell #(
    parameter int IDX = 0
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   en,
    input  logic                                   vld_i,
    input  gcd_pkg::root_t [gcd_pkg::NROOT-1:0]    d_i,
    output logic                                   vld_o,
    output gcd_pkg::root_t [gcd_pkg::NROOT-1:0]    d_o
);

    localparam logic [gcd_pkg::RW-1:0] BIT = gcd_pkg::RW'(1) << (62 - 2 * IDX);

    logic                                  vld_reg;
    gcd_pkg::root_t [gcd_pkg::NROOT-1:0]   d_reg;
    gcd_pkg::root_t [gcd_pkg::NROOT-1:0]   d_next;
    logic [gcd_pkg::RW-1:0]                trial [gcd_pkg::NROOT];

    always_comb begin
        for (int k = 0; k < gcd_pkg::NROOT; k++) begin
            trial[k] = d_i[k].res + BIT;
            if (d_i[k].n >= trial[k]) begin
                d_next[k].n   = d_i[k].n - trial[k];
                d_next[k].res = (d_i[k].res >> 1) + BIT;
            end else begin
                d_next[k].n   = d_i[k].n;
                d_next[k].res = d_i[k].res >> 1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg <= vld_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_reg <= d_next;
        end
    end

    assign vld_o = vld_reg;
    assign d_o   = d_reg;

endmodule

// ===== design/great_circle_distance_unit.sv =====
// ----------------------------------------------------------------------------
// great_circle_distance_unit - haversine distance between two points
// Fixed-point pipeline: angle reduction, radian conversion, CORDIC sine and
// cosine, haversine term, square roots and a vectoring CORDIC arcsine.
//
//   channel | direction | tdata fields (lowest bit first)
//   s_      | in        | lat_a[23:0] lon_a[48:24] lat_b[72:49] lon_b[97:73]
//   m_      | out       | dist_km[22:0]
//
// One request enters per cycle unless the row is stalled; the depth to the output
// register is set by the length of the cell rows.
// Reset (aresetn low, synchronous) empties every stage; data holds no reset.
// A full output register that is not taken stalls the whole row of stages;
// any bubble in the last stage lets the row advance anyway.
// ----------------------------------------------------------------------------
module great_circle_distance_unit #(
    parameter int CORDIC_STEPS = 24
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [103:0]  s_tdata,   // lat_a, lon_a, lat_b, lon_b, zero pad
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [23:0]   m_tdata    // dist_km, zero pad
);

    localparam int AW = gcd_pkg::AW;
    localparam int TW = gcd_pkg::TW;
    localparam int CW = gcd_pkg::CW;
    localparam int RS = gcd_pkg::ROOT_STEPS;

    // rounded Q30 product: floor((a*b + 2^29) / 2^30)
    function automatic logic signed [31:0] mulq(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        logic signed [63:0] p;
        p = a * b + 64'sd536870912;
        return 32'(p >>> 30);
    endfunction

    // global advance: hold everything only when the last stage would overrun
    logic adv;

    // input fields
    logic signed [23:0] lat_a, lat_b;
    logic signed [24:0] lon_a, lon_b;

    assign lat_a = signed'(s_tdata[23:0]);
    assign lon_a = signed'(s_tdata[48:24]);
    assign lat_b = signed'(s_tdata[72:49]);
    assign lon_b = signed'(s_tdata[97:73]);

    // ---------------- angle preparation (three stages) ----------------
    logic                vp1_reg, vp2_reg, vp3_reg;
    logic signed [25:0]  red_reg  [gcd_pkg::NLANE];
    logic signed [25:0]  red_next [gcd_pkg::NLANE];
    logic [23:0]         mag_reg  [gcd_pkg::NLANE];
    logic [23:0]         mag_next [gcd_pkg::NLANE];
    logic                sgn_reg  [gcd_pkg::NLANE];
    logic                sgn_next [gcd_pkg::NLANE];
    logic                ngc_reg  [gcd_pkg::NLANE];
    logic                ngc_next [gcd_pkg::NLANE];
    logic signed [26:0]  raw      [gcd_pkg::NLANE];
    logic signed [26:0]  fold     [gcd_pkg::NLANE];
    gcd_pkg::angle_t [gcd_pkg::NLANE-1:0] ang_reg;
    gcd_pkg::angle_t [gcd_pkg::NLANE-1:0] ang_next;

    // reduce into [-180, 180) degrees
    always_comb begin
        raw[0] = 27'(lat_b) - 27'(lat_a);
        raw[1] = 27'(lon_b) - 27'(lon_a);
        raw[2] = 27'(lat_a) + 27'(lat_a);
        raw[3] = 27'(lat_b) + 27'(lat_b);
        for (int k = 0; k < gcd_pkg::NLANE; k++) begin
            if (raw[k] >= gcd_pkg::DEG_180) begin
                red_next[k] = 26'(raw[k] - gcd_pkg::DEG_360);
            end else if (raw[k] < -gcd_pkg::DEG_180) begin
                red_next[k] = 26'(raw[k] + gcd_pkg::DEG_360);
            end else begin
                red_next[k] = 26'(raw[k]);
            end
        end
    end

    // fold into [-90, 90], flag the cosine for negation, split sign
    always_comb begin
        for (int k = 0; k < gcd_pkg::NLANE; k++) begin
            fold[k]     = 27'(red_reg[k]);
            ngc_next[k] = 1'b0;
            if (fold[k] > gcd_pkg::DEG_90) begin
                fold[k]     = gcd_pkg::DEG_180 - 27'(red_reg[k]);
                ngc_next[k] = 1'b1;
            end else if (fold[k] < -gcd_pkg::DEG_90) begin
                fold[k]     = -gcd_pkg::DEG_180 - 27'(red_reg[k]);
                ngc_next[k] = 1'b1;
            end
            sgn_next[k] = fold[k] < 0;
            mag_next[k] = sgn_next[k] ? 24'(-fold[k]) : 24'(fold[k]);
        end
    end

    // split mag * pi + half by pi = 45 * q + r: the high part is already a
    // multiple of 45, only the low part is left to divide
    always_comb begin
        for (int k = 0; k < gcd_pkg::NLANE; k++) begin
            ang_next[k].sign = sgn_reg[k];
            ang_next[k].negc = ngc_reg[k];
            ang_next[k].hi   = AW'(mag_reg[k]) * AW'(gcd_pkg::PI_DIV45);
            ang_next[k].lo   = TW'(mag_reg[k]) * TW'(gcd_pkg::PI_MOD45)
                               + TW'(gcd_pkg::HALF_DEG);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            red_reg <= red_next;
            mag_reg <= mag_next;
            sgn_reg <= sgn_next;
            ngc_reg <= ngc_next;
            ang_reg <= ang_next;
        end
    end

    // ---------------- division by 45 by reciprocal multiplication ----------------
    gcd_pkg::angle_t [gcd_pkg::NLANE-1:0] div_d;
    logic                                 div_v;

    gcd_div_cell u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (adv),
        .vld_i   (vp3_reg),
        .d_i     (ang_reg),
        .vld_o   (div_v),
        .d_o     (div_d)
    );

    // ---------------- rotation CORDIC: sine and cosine ----------------
    gcd_pkg::cord_t [gcd_pkg::NLANE-1:0] rot_d [CORDIC_STEPS+1];
    logic                                rot_v [CORDIC_STEPS+1];
    logic [1:0]                          negc_reg [CORDIC_STEPS];

    // drop the 2^19 factor of the divisor to get radians Q30
    for (genvar k = 0; k < gcd_pkg::NLANE; k++) begin : g_rot_in
        assign rot_d[0][k].x = gcd_pkg::GAIN_Q30;
        assign rot_d[0][k].y = '0;
        assign rot_d[0][k].z = div_d[k].sign ? -CW'(div_d[k].hi[49:19])
                                             : CW'(div_d[k].hi[49:19]);
    end
    assign rot_v[0] = div_v;

    // carry the cosine negation flags of the two latitude lanes alongside
    always_ff @(posedge aclk) begin
        if (adv) begin
            negc_reg[0] <= {div_d[3].negc, div_d[2].negc};
            for (int i = 1; i < CORDIC_STEPS; i++) begin
                negc_reg[i] <= negc_reg[i-1];
            end
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
        gcd_cordic_cell #(
            .IDX    (i),
            .VECTOR (1'b0),
            .LANES  (gcd_pkg::NLANE)
        ) u_rot (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (adv),
            .vld_i   (rot_v[i]),
            .d_i     (rot_d[i]),
            .vld_o   (rot_v[i+1]),
            .d_o     (rot_d[i+1])
        );
    end

    // ---------------- haversine term (three stages) ----------------
    logic               vm1_reg, vm2_reg, vm3_reg;
    logic signed [31:0] sin_dlat, sin_dlon, cos_a, cos_b;
    logic signed [31:0] p1_reg, p2_reg, p3_reg, q1_reg, p4_reg;
    logic signed [32:0] hsum;
    logic [30:0]        h_reg, h_next;

    always_comb begin
        sin_dlat = 32'(rot_d[CORDIC_STEPS][0].y);
        sin_dlon = 32'(rot_d[CORDIC_STEPS][1].y);
        cos_a    = negc_reg[CORDIC_STEPS-1][0] ? -32'(rot_d[CORDIC_STEPS][2].x)
                                               : 32'(rot_d[CORDIC_STEPS][2].x);
        cos_b    = negc_reg[CORDIC_STEPS-1][1] ? -32'(rot_d[CORDIC_STEPS][3].x)
                                               : 32'(rot_d[CORDIC_STEPS][3].x);
        // clamp h to [0, 1.0]
        hsum = 33'(q1_reg) + 33'(p4_reg);
        if (hsum < 0) begin
            h_next = '0;
        end else if (hsum > signed'(33'(gcd_pkg::ONE_Q30))) begin
            h_next = gcd_pkg::ONE_Q30;
        end else begin
            h_next = hsum[30:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p1_reg <= mulq(sin_dlat, sin_dlat);
            p2_reg <= mulq(cos_a, cos_b);
            p3_reg <= mulq(sin_dlon, sin_dlon);
            q1_reg <= p1_reg;
            p4_reg <= mulq(p2_reg, p3_reg);
            h_reg  <= h_next;
        end
    end

    // ---------------- square roots of h and 1-h ----------------
    gcd_pkg::root_t [gcd_pkg::NROOT-1:0] root_d [RS+1];
    logic                                root_v [RS+1];

    assign root_d[0][0].n   = gcd_pkg::RW'(h_reg) << 30;
    assign root_d[0][0].res = '0;
    assign root_d[0][1].n   = gcd_pkg::RW'(gcd_pkg::ONE_Q30 - h_reg) << 30;
    assign root_d[0][1].res = '0;
    assign root_v[0] = vm3_reg;

    for (genvar i = 0; i < RS; i++) begin : g_root
        gcd_root_cell #(
            .IDX (i)
        ) u_root (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (adv),
            .vld_i   (root_v[i]),
            .d_i     (root_d[i]),
            .vld_o   (root_v[i+1]),
            .d_o     (root_d[i+1])
        );
    end

    // ---------------- vectoring CORDIC: atan2(sqrt(h), sqrt(1-h)) ----------------
    gcd_pkg::cord_t [0:0] vec_d [CORDIC_STEPS+1];
    logic                 vec_v [CORDIC_STEPS+1];

    assign vec_d[0][0].x = signed'(CW'(root_d[RS][1].res[31:0]));
    assign vec_d[0][0].y = signed'(CW'(root_d[RS][0].res[31:0]));
    assign vec_d[0][0].z = '0;
    assign vec_v[0] = root_v[RS];

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_vec
        gcd_cordic_cell #(
            .IDX    (i),
            .VECTOR (1'b1),
            .LANES  (1)
        ) u_vec (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (adv),
            .vld_i   (vec_v[i]),
            .d_i     (vec_d[i]),
            .vld_o   (vec_v[i+1]),
            .d_o     (vec_d[i+1])
        );
    end

    // ---------------- scale to km, saturate, output register ----------------
    logic                 vf_reg;
    logic signed [CW-1:0] arc;
    logic [32:0]          arc_pos;
    logic [46:0]          dist_full;
    logic [24:0]          dist_reg;
    logic                 out_vld_reg, out_vld_next;
    logic [22:0]          out_data_reg, out_data_next;

    always_comb begin
        arc       = vec_d[CORDIC_STEPS][0].z;
        arc_pos   = (arc < 0) ? '0 : arc[32:0];     // drop a small negative arc
        dist_full = 47'(arc_pos) * 47'(gcd_pkg::DIST_SCALE) + 47'(2097152);
        out_data_next = (dist_reg > 25'(gcd_pkg::DIST_MAX)) ? gcd_pkg::DIST_MAX
                                                          : dist_reg[22:0];
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            dist_reg <= dist_full[46:22];
        end
    end

    // advance unless a finished request sits in front of a full output that is not taken
    assign adv = !vf_reg || !out_vld_reg || m_tready;

    always_comb begin
        out_vld_next = out_vld_reg;
        if (m_tready) begin
            out_vld_next = 1'b0;
        end
        if (adv && vf_reg) begin
            out_vld_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && vf_reg) begin
            out_data_reg <= out_data_next;
        end
    end

    // stage valid flags of the top-level stages
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vp1_reg     <= 1'b0;
            vp2_reg     <= 1'b0;
            vp3_reg     <= 1'b0;
            vm1_reg     <= 1'b0;
            vm2_reg     <= 1'b0;
            vm3_reg     <= 1'b0;
            vf_reg      <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            if (adv) begin
                vp1_reg <= s_tvalid;
                vp2_reg <= vp1_reg;
                vp3_reg <= vp2_reg;
                vm1_reg <= rot_v[CORDIC_STEPS];
                vm2_reg <= vm1_reg;
                vm3_reg <= vm2_reg;
                vf_reg  <= vec_v[CORDIC_STEPS];
            end
            out_vld_reg <= out_vld_next;
        end
    end

    assign s_tready = adv;
    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {1'b0, out_data_reg};

`ifndef ASSERT_OFF
    // the input side only stalls behind an unread result
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled without a blocked result");

    // a delivered distance never exceeds the saturation limit
    a_dist_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[22:0] <= gcd_pkg::DIST_MAX))
        else $error("distance above saturation limit");

    // the clamped haversine term stays within [0, 1.0]
    a_h_clamp: assert property (@(posedge aclk) disable iff (!aresetn)
        vm3_reg |-> (h_reg <= gcd_pkg::ONE_Q30))
        else $error("haversine term out of range");

    // a result taken while nothing new arrives leaves the output empty
    a_out_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !vf_reg) |=> !m_tvalid)
        else $error("output valid held after drain");
`endif

endmodule
